[rtl/pid_with_integral_clamp_unit_macros.svh]
// ----------------------------------------------------------------------------
// PID unit assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PID_WITH_INTEGRAL_CLAMP_UNIT_MACROS_SVH
`define PID_WITH_INTEGRAL_CLAMP_UNIT_MACROS_SVH

// Same-cycle implication.
`define PCU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pcu_pkg.sv]
// ----------------------------------------------------------------------------
// PID unit package
// Widths, register indexes and derived constants of the PID regulator.
// ----------------------------------------------------------------------------
package pcu_pkg;

  // Accumulator width of the integral term.
  localparam int ACCUM_BITS = 24;

  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 23;
  localparam int DIV_W   = 8;
  localparam int DRV_W   = 32;
  localparam int CFG_W   = 23;
  localparam int IDX_W   = 3;
  localparam int FRAC_W  = 8;

  // Widths for the clamp compare and the final sum.
  localparam int LIM_W  = (ACCUM_BITS - 1 > LIMIT_W) ? ACCUM_BITS - 1 : LIMIT_W;
  localparam int CMP_W  = (ACCUM_BITS + 1 > LIM_W + 1) ? ACCUM_BITS + 1 : LIM_W + 1;
  localparam int PI_W   = GAIN_W + ACCUM_BITS;
  localparam int PP_W   = GAIN_W + ERR_W;
  localparam int PD_W   = GAIN_W + ERR_W + 1;
  localparam int SUM_W  = ((PI_W > 40) ? PI_W : 40) + 2;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_INTEG_LIMIT  = 3'd3,
    REG_TICK_DIVIDER = 3'd4,
    REG_ENABLE       = 3'd5
  } cfg_reg_t;

endpackage

[rtl/pid_with_integral_clamp_unit.sv]
// ----------------------------------------------------------------------------
// PID regulator with anti-windup clamp
// Single-channel PID update with a clamped integral and a tick divider.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   input    | in_valid / in_ready  | error_sample (16b signed)
//   result   | out_valid / out_ready| drive_value (32b signed)
//   config   | cfg_valid / cfg_ready| cfg_index (3b), cfg_data (23b)
//
// One request per cycle while no result waits; a request that fires an update
// passes the operand, product and result registers behind the input register.
// The accumulator add and clamp are combinational, which sets the rate.
// A waiting result stalls the whole pipeline; config writes are always taken.
// Reset restores gains 0, limit 0, divider 1, disabled, state cleared.
// ----------------------------------------------------------------------------
`include "pid_with_integral_clamp_unit_macros.svh"

module pid_with_integral_clamp_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pcu_pkg::ERR_W-1:0]     error_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pcu_pkg::DRV_W-1:0]     drive_value,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pcu_pkg::IDX_W-1:0]            cfg_index,
  input  logic [pcu_pkg::CFG_W-1:0]            cfg_data
);

  localparam int AB = pcu_pkg::ACCUM_BITS;

  // configuration
  logic signed [pcu_pkg::GAIN_W-1:0]  prop_gain;
  logic signed [pcu_pkg::GAIN_W-1:0]  integ_gain;
  logic signed [pcu_pkg::GAIN_W-1:0]  deriv_gain;
  logic [pcu_pkg::LIMIT_W-1:0]        integ_limit;
  logic [pcu_pkg::DIV_W-1:0]          tick_divider;
  logic                               enable;

  // loop state
  logic signed [AB-1:0]               error_accum;
  logic signed [pcu_pkg::ERR_W-1:0]   prev_error;
  logic [pcu_pkg::DIV_W-1:0]          tick_count;

  // stage 1: input register
  logic                               v1;
  logic signed [pcu_pkg::ERR_W-1:0]   e1;

  // stage 2: update operands
  logic                               v2;
  logic signed [pcu_pkg::ERR_W-1:0]   e2;
  logic signed [AB-1:0]               acc2;
  logic signed [pcu_pkg::ERR_W:0]     diff2;

  // stage 3: products
  logic                               v3;
  logic signed [pcu_pkg::PP_W-1:0]    p_prop;
  logic signed [pcu_pkg::PI_W-1:0]    p_integ;
  logic signed [pcu_pkg::PD_W-1:0]    p_deriv;

  logic                               adv;
  logic [pcu_pkg::DIV_W-1:0]          div_eff;
  logic [pcu_pkg::DIV_W-1:0]          tick_inc;
  logic [pcu_pkg::DIV_W-1:0]          tick_count_next;
  logic                               hit;
  logic                               upd;
  logic signed [pcu_pkg::CMP_W-1:0]   lim;
  logic signed [pcu_pkg::CMP_W-1:0]   acc_sum;
  logic signed [AB-1:0]               error_accum_next;
  logic signed [pcu_pkg::SUM_W-1:0]   sum;
  logic signed [pcu_pkg::SUM_W-1:0]   shifted;
  logic signed [pcu_pkg::DRV_W-1:0]   drive_next;

  localparam logic signed [pcu_pkg::CMP_W-1:0] ACC_MAX =
    pcu_pkg::CMP_W'((64'sd1 <<< (AB - 1)) - 64'sd1);
  localparam logic signed [pcu_pkg::SUM_W-1:0] DRV_MAX =
    pcu_pkg::SUM_W'($signed({1'b0, {(pcu_pkg::DRV_W-1){1'b1}}}));
  localparam logic signed [pcu_pkg::SUM_W-1:0] DRV_MIN =
    pcu_pkg::SUM_W'($signed({1'b1, {(pcu_pkg::DRV_W-1){1'b0}}}));

  // the pipeline moves as one unless a result is waiting
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      integ_limit  <= '0;
      tick_divider <= pcu_pkg::DIV_W'(1);
      enable       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pcu_pkg::cfg_reg_t'(cfg_index))
        pcu_pkg::REG_PROP_GAIN:    prop_gain    <= cfg_data[pcu_pkg::GAIN_W-1:0];
        pcu_pkg::REG_INTEG_GAIN:   integ_gain   <= cfg_data[pcu_pkg::GAIN_W-1:0];
        pcu_pkg::REG_DERIV_GAIN:   deriv_gain   <= cfg_data[pcu_pkg::GAIN_W-1:0];
        pcu_pkg::REG_INTEG_LIMIT:  integ_limit  <= cfg_data[pcu_pkg::LIMIT_W-1:0];
        pcu_pkg::REG_TICK_DIVIDER: tick_divider <= cfg_data[pcu_pkg::DIV_W-1:0];
        pcu_pkg::REG_ENABLE:       enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // tick counter and clamped accumulator
  always_comb begin
    div_eff  = (tick_divider == '0) ? pcu_pkg::DIV_W'(1) : tick_divider;
    tick_inc = tick_count + pcu_pkg::DIV_W'(1);
    hit      = (tick_inc == div_eff);
    tick_count_next = hit ? '0 : tick_inc;
    upd      = v1 && hit && enable;

    // clamp magnitude is the smaller of the register and the accumulator range
    if (pcu_pkg::CMP_W'(integ_limit) < ACC_MAX) begin
      lim = pcu_pkg::CMP_W'(integ_limit);
    end else begin
      lim = ACC_MAX;
    end

    acc_sum = pcu_pkg::CMP_W'(error_accum) + pcu_pkg::CMP_W'(e1);
    priority if (acc_sum > lim) begin
      error_accum_next = AB'(lim);
    end else if (acc_sum < -lim) begin
      error_accum_next = AB'(-lim);
    end else begin
      error_accum_next = AB'(acc_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      error_accum <= '0;
      prev_error  <= '0;
    end else if (adv && v1) begin
      tick_count <= tick_count_next;
      if (upd) begin
        error_accum <= error_accum_next;
        prev_error  <= e1;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= upd;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // final sum, floor shift and saturation
  always_comb begin
    sum = pcu_pkg::SUM_W'(p_prop) + pcu_pkg::SUM_W'(p_integ)
        + pcu_pkg::SUM_W'(p_deriv);
    shifted = sum >>> pcu_pkg::FRAC_W;
    priority if (shifted > DRV_MAX) begin
      drive_next = DRV_MAX[pcu_pkg::DRV_W-1:0];
    end else if (shifted < DRV_MIN) begin
      drive_next = DRV_MIN[pcu_pkg::DRV_W-1:0];
    end else begin
      drive_next = shifted[pcu_pkg::DRV_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      e1      <= error_sample;
      e2      <= e1;
      acc2    <= error_accum_next;
      diff2   <= (pcu_pkg::ERR_W+1)'(e1) - (pcu_pkg::ERR_W+1)'(prev_error);
      p_prop  <= prop_gain * e2;
      p_integ <= integ_gain * acc2;
      p_deriv <= deriv_gain * diff2;
      drive_value <= drive_next;
    end
  end

  `PCU_ASSERT_NOW(a_stall_only_on_result, !in_ready, out_valid, "stall without result")
  `PCU_ASSERT_NEXT(a_input_captured, in_valid && in_ready,
    v1 && (e1 == $past(error_sample)), "request not captured")
  `PCU_ASSERT_NEXT(a_prev_follows_update, adv && upd,
    (prev_error == $past(e1)) && v2, "update lost")
  `PCU_ASSERT_NEXT(a_result_follows_products, adv && v3, out_valid, "result lost")

endmodule

[dv/pid_with_integral_clamp_unit_tb.sv]
// ----------------------------------------------------------------------------
// PID regulator testbench
// Drives error ticks and register writes with random idle and stall cycles.
// A built-in PID predictor (divider, clamped integral, Q8.8 gains) or a directed
// row gives each expected drive value, checked in order. A short directed table
// comes first, then a run of wrap ticks, then random phases.
module pid_with_integral_clamp_unit_tb;
  import pcu_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WRAP_ITEMS     = 260;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 45;
  localparam int DIR_ROWS       = 42;

  localparam longint DRV_MAX = (longint'(1) <<< (DRV_W - 1)) - 1;
  localparam longint DRV_MIN = -(longint'(1) <<< (DRV_W - 1));

  typedef struct {
    bit                      wr;
    logic [IDX_W-1:0]        idx;
    logic [CFG_W-1:0]        data;
    logic signed [ERR_W-1:0] err;
    bit                      typed;
    logic signed [DRV_W-1:0] drive;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [ERR_W-1:0] error_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [DRV_W-1:0] drive_value;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  // predictor copy of the registers and the loop state
  logic signed [GAIN_W-1:0]     kp_q = '0;
  logic signed [GAIN_W-1:0]     ki_q = '0;
  logic signed [GAIN_W-1:0]     kd_q = '0;
  logic [LIMIT_W-1:0]           clamp_mag = '0;
  logic [DIV_W-1:0]             upd_div = 8'd1;
  logic                         loop_on = 1'b0;
  logic signed [ACCUM_BITS-1:0] integ_sum = '0;
  logic signed [ERR_W-1:0]      last_err = '0;
  logic [DIV_W-1:0]             tick_ctr = '0;

  logic signed [DRV_W-1:0] drive_q[$];
  int                      mismatches = 0;
  int                      idle_cycles = 0;
  bit                      quiet_in = 1'b0;
  bit                      quiet_out = 1'b0;
  stim_row_t               directed[DIR_ROWS];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pid_with_integral_clamp_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .error_sample (error_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_value  (drive_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic stim_row_t wr_row(input logic [IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    stim_row_t r;
    r = '{wr: 1'b1, idx: idx, data: data, err: '0, typed: 1'b0, drive: '0};
    return r;
  endfunction

  function automatic stim_row_t tick_row(input logic signed [ERR_W-1:0] err);
    stim_row_t r;
    r = '{wr: 1'b0, idx: '0, data: '0, err: err, typed: 1'b0, drive: '0};
    return r;
  endfunction

  function automatic stim_row_t chk_row(input logic signed [ERR_W-1:0] err,
                                        input logic signed [DRV_W-1:0] drive);
    stim_row_t r;
    r = '{wr: 1'b0, idx: '0, data: '0, err: err, typed: 1'b1, drive: drive};
    return r;
  endfunction

  function automatic logic signed [ERR_W-1:0] pick_error();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3, 4, 5: return ERR_W'(int'($urandom_range(0, 128)) - 64);
      default: return ERR_W'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic apply_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_PROP_GAIN:    kp_q = data[GAIN_W-1:0];
      REG_INTEG_GAIN:   ki_q = data[GAIN_W-1:0];
      REG_DERIV_GAIN:   kd_q = data[GAIN_W-1:0];
      REG_INTEG_LIMIT:  clamp_mag = data[LIMIT_W-1:0];
      REG_TICK_DIVIDER: upd_div = data[DIV_W-1:0];
      REG_ENABLE:       loop_on = data[0];
      default: ;
    endcase
  endtask

  // One control tick: advance the divider, run the clamped PID update on a match while enabled.
  task automatic step_pid(input logic signed [ERR_W-1:0] e, output bit fired,
                          output logic signed [DRV_W-1:0] val);
    longint           lim, acc, sum, res;
    logic [DIV_W-1:0] div;
    fired = 1'b0;
    val = '0;
    div = upd_div;
    if (div == '0) div = 8'd1;
    tick_ctr = tick_ctr + 1'b1;
    if (tick_ctr != div) return;
    tick_ctr = '0;
    if (!loop_on) return;
    lim = (longint'(1) <<< (ACCUM_BITS - 1)) - 1;
    if (longint'(clamp_mag) < lim) lim = longint'(clamp_mag);
    acc = longint'(integ_sum) + longint'(e);
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    integ_sum = ACCUM_BITS'(acc);
    sum = longint'(kp_q) * longint'(e) + longint'(ki_q) * acc +
          longint'(kd_q) * (longint'(e) - longint'(last_err));
    last_err = e;
    res = sum >>> FRAC_W;
    if (res > DRV_MAX) res = DRV_MAX;
    else if (res < DRV_MIN) res = DRV_MIN;
    fired = 1'b1;
    val = DRV_W'(res);
  endtask

  task automatic send_tick(input logic signed [ERR_W-1:0] e, input bit typed,
                           input logic signed [DRV_W-1:0] typed_drive);
    bit                      fired;
    logic signed [DRV_W-1:0] val;
    int                      gap;
    cfg_valid <= 1'b0;
    in_valid <= 1'b1;
    error_sample <= e;
    do @(posedge clk); while (!in_ready);
    step_pid(e, fired, val);
    if (fired) drive_q.push_back(typed ? typed_drive : val);
    gap = quiet_in ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
  endtask

  // Drain all results, then let a tick that makes no result leave the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] data;
    logic [GAIN_W-1:0] gain;
    directed = '{
      tick_row(100),
      wr_row(REG_PROP_GAIN, 23'h7f0100),
      wr_row(REG_ENABLE, 23'h000001),
      chk_row(32767, 32767),
      chk_row(-32768, -32768),
      wr_row(REG_PROP_GAIN, 23'h008000),
      chk_row(-32768, 4194304),
      chk_row(32767, -4194176),
      wr_row(REG_PROP_GAIN, 23'h000001),
      chk_row(-1, -1),
      wr_row(REG_PROP_GAIN, 23'h000000),
      wr_row(REG_INTEG_GAIN, 23'h000100),
      wr_row(REG_INTEG_LIMIT, 23'h000005),
      chk_row(3, 3),
      chk_row(10, 5),
      chk_row(-32768, -5),
      wr_row(REG_INTEG_LIMIT, 23'h7fffff),
      wr_row(REG_INTEG_GAIN, 23'h007fff),
      tick_row(32767),
      tick_row(32767),
      wr_row(REG_DERIV_GAIN, 23'h008000),
      wr_row(REG_INTEG_GAIN, 23'h000000),
      tick_row(-32768),
      tick_row(32767),
      wr_row(REG_SPARE_6, 23'h7fffff),
      wr_row(REG_SPARE_7, 23'h000001),
      wr_row(REG_TICK_DIVIDER, 23'h7fff00),
      tick_row(5),
      tick_row(-5),
      wr_row(REG_TICK_DIVIDER, 23'h000003),
      tick_row(1),
      tick_row(2),
      tick_row(3),
      wr_row(REG_ENABLE, 23'h7ffffe),
      tick_row(7),
      tick_row(7),
      tick_row(7),
      wr_row(REG_ENABLE, 23'h000001),
      wr_row(REG_TICK_DIVIDER, 23'h000005),
      tick_row(9),
      tick_row(9),
      wr_row(REG_TICK_DIVIDER, 23'h000001)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].wr) begin
        wait_idle();
        cfg_write(directed[i].idx, directed[i].data);
      end else begin
        send_tick(directed[i].err, directed[i].typed, directed[i].drive);
      end
    end

    // hold the config: the divider was lowered below the count, so let it wrap
    repeat (WRAP_ITEMS) send_tick(pick_error(), 1'b0, '0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      for (int r = REG_PROP_GAIN; r <= REG_ENABLE; r++) begin
        if ($urandom_range(0, 1) == 0) continue;
        case ($urandom_range(0, 5))
          0: gain = 16'h8000;
          1: gain = 16'h7fff;
          2: gain = 16'h0100;
          3: gain = '0;
          4: gain = GAIN_W'(int'($urandom_range(0, 2048)) - 1024);
          default: gain = GAIN_W'($urandom);
        endcase
        data = {7'($urandom), gain};
        case (r)
          REG_INTEG_LIMIT: begin
            case ($urandom_range(0, 4))
              0: data = '0;
              1: data = 23'h7fffff;
              2: data = CFG_W'($urandom_range(0, 100));
              3: data = CFG_W'($urandom_range(0, 4095));
              default: data = CFG_W'($urandom);
            endcase
          end
          REG_TICK_DIVIDER: begin
            case ($urandom_range(0, 7))
              0: data = {15'($urandom), 8'd0};
              1: data = {15'($urandom), 8'd255};
              2: data = {15'($urandom), 8'($urandom)};
              default: data = {15'($urandom), 8'($urandom_range(1, 6))};
            endcase
          end
          REG_ENABLE: data = {22'($urandom), 1'($urandom_range(0, 3) != 0)};
          default: ;
        endcase
        cfg_write(r[IDX_W-1:0], data);
      end
      if ($urandom_range(0, 7) == 0)
        cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_W'($urandom));
      repeat (PHASE_ITEMS) send_tick(pick_error(), 1'b0, '0);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: stall a random number of cycles (none when quiet) before taking each result
  initial begin
    int stall;
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready && !rst));
    end
  end

  always @(posedge clk) begin
    logic signed [DRV_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected drive_value %0d", drive_value));
      end else begin
        want = drive_q.pop_front();
        if (drive_value !== want)
          flag_mismatch($sformatf("drive_value got %0d want %0d", drive_value, want));
      end
    end
  end

  // end the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[sim.f]
+incdir+rtl
rtl/pcu_pkg.sv
rtl/pid_with_integral_clamp_unit.sv
dv/pid_with_integral_clamp_unit_tb.sv
